/* design/tcpra_pkg.sv */
// ----------------------------------------------------------------------------
// tcpra_pkg
// Shared types and constants of the cumulative-ack segment receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpra_pkg;

  // Default depth of the out-of-order hold set
  localparam int unsigned HOLD_DEPTH = 16;

  // Register port address width and register index decode
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_IDX_TOTAL_BYTES = 1'b0;

  // Arriving segment request
  typedef struct packed {
    logic [31:0] seg_seq;
    logic [15:0] seg_bytes;
  } seg_req_t;

  // Acknowledgement
  typedef struct packed {
    logic [31:0] ack_expected;
    logic [31:0] ack_of_seq;
    logic        was_new;
    logic        transfer_done;
    logic        set_overflow;
  } ack_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_INS_SCAN,
    ST_INS_COMMIT,
    ST_DRAIN_SCAN,
    ST_COUNT,
    ST_REPLY
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // load the accepted request
    logic scan_start;  // clear scan address, counters and flags
    logic scan_run;    // issue a hold-set read and compare the previous one
    logic drain;       // scan target is next_expected, else the segment
    logic advance;     // in-order segment: bump next_expected
    logic commit;      // place the segment in the hold set if possible
    logic count;       // add payload bytes when the segment is new
    logic load_out;    // load the acknowledgement register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic seq_gt;      // segment above next_expected
    logic seq_eq;      // segment at next_expected
    logic scan_done;   // scan has finished
  } dp_status_t;

endpackage

`default_nettype wire

/* design/tcpra_dpath.sv */
// ----------------------------------------------------------------------------
// tcpra_dpath
// Receiver datapath: expected sequence, byte count, hold-set memory with a
// one-entry-per-cycle scan unit, and the acknowledgement register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpra_dpath #(
  parameter int unsigned HoldDepth = tcpra_pkg::HOLD_DEPTH
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  tcpra_pkg::seg_req_t     req_i,
  input  wire  [31:0]             total_bytes_i,
  input  tcpra_pkg::dp_cmd_t      cmd_i,
  output tcpra_pkg::dp_status_t   status_o,
  output tcpra_pkg::ack_t         ack_o
);
  import tcpra_pkg::*;

  localparam int unsigned AW = (HoldDepth > 1) ? $clog2(HoldDepth) : 1;
  localparam int unsigned CW = $clog2(HoldDepth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(HoldDepth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(HoldDepth);

  // Captured request
  logic [31:0] seq_q;
  logic [15:0] nbytes_q;

  // Receiver state
  logic [31:0]          ne_q, ne_d;
  logic [31:0]          bytes_q, bytes_d;
  logic [HoldDepth-1:0] valid_q, valid_d;

  // Hold-set memory and scan pipeline
  logic [31:0]   mem_q [HoldDepth];
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] rd_idx_q;
  logic [31:0]   rd_data_q;
  logic          rd_vld_q, rd_vld_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          found_q, found_d;
  logic          free_vld_q, free_vld_d;
  logic [AW-1:0] free_idx_q, free_idx_d;

  // Per-segment outcome
  logic fresh_q, fresh_d;
  logic ovf_q, ovf_d;

  ack_t out_q;

  logic [31:0] target;
  logic        scan_done;
  logic        cmp_en;
  logic        entry_vld;
  logic        hit;
  logic        place;
  logic [32:0] sum;

  // Compare the read entry against the current scan target
  assign target    = cmd_i.drain ? ne_q : seq_q;
  assign scan_done = (cnt_q == FullCnt);
  assign cmp_en    = cmd_i.scan_run && rd_vld_q && !scan_done;
  assign entry_vld = valid_q[rd_idx_q];
  assign hit       = cmp_en && entry_vld && (rd_data_q == target);
  assign place     = cmd_i.commit && !found_q && free_vld_q;
  assign sum       = {1'b0, bytes_q} + {17'd0, nbytes_q};

  // Next-state logic of scan and receiver state
  always_comb begin
    ne_d       = ne_q;
    bytes_d    = bytes_q;
    valid_d    = valid_q;
    addr_d     = addr_q;
    rd_vld_d   = rd_vld_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    fresh_d    = fresh_q;
    ovf_d      = ovf_q;

    if (cmd_i.capture) begin
      fresh_d = 1'b0;
      ovf_d   = 1'b0;
    end

    if (cmd_i.advance) begin
      ne_d    = ne_q + 32'd1;
      fresh_d = 1'b1;
    end

    if (cmd_i.scan_start) begin
      addr_d     = '0;
      rd_vld_d   = 1'b0;
      cnt_d      = '0;
      found_d    = 1'b0;
      free_vld_d = 1'b0;
    end else if (cmd_i.scan_run) begin
      addr_d   = (addr_q == LastIdx) ? '0 : addr_q + AW'(1);
      rd_vld_d = 1'b1;
    end

    // Drain: a hit removes the entry and restarts the miss count
    if (cmp_en && cmd_i.drain) begin
      if (hit) begin
        valid_d[rd_idx_q] = 1'b0;
        ne_d              = ne_q + 32'd1;
        cnt_d             = '0;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end

    // Insert: one pass for duplicate check and lowest free entry
    if (cmp_en && !cmd_i.drain) begin
      cnt_d = cnt_q + CW'(1);
      if (hit) begin
        found_d = 1'b1;
      end
      if (!entry_vld && !free_vld_q) begin
        free_vld_d = 1'b1;
        free_idx_d = rd_idx_q;
      end
    end

    if (cmd_i.commit && !found_q) begin
      if (free_vld_q) begin
        valid_d[free_idx_q] = 1'b1;
        fresh_d             = 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    // Saturating byte count
    if (cmd_i.count && fresh_q) begin
      bytes_d = sum[32] ? '1 : sum[31:0];
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q       <= '0;
      bytes_q    <= '0;
      valid_q    <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      cnt_q      <= '0;
      found_q    <= 1'b0;
      free_vld_q <= 1'b0;
      fresh_q    <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      ne_q       <= ne_d;
      bytes_q    <= bytes_d;
      valid_q    <= valid_d;
      addr_q     <= addr_d;
      rd_vld_q   <= rd_vld_d;
      cnt_q      <= cnt_d;
      found_q    <= found_d;
      free_vld_q <= free_vld_d;
      fresh_q    <= fresh_d;
      ovf_q      <= ovf_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    if (cmd_i.capture) begin
      seq_q    <= req_i.seg_seq;
      nbytes_q <= req_i.seg_bytes;
    end
    if (cmd_i.load_out) begin
      out_q.ack_expected  <= ne_q;
      out_q.ack_of_seq    <= seq_q;
      out_q.was_new       <= fresh_q;
      out_q.transfer_done <= (bytes_q == total_bytes_i);
      out_q.set_overflow  <= ovf_q;
    end
  end

  // Hold-set memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (place) begin
      mem_q[free_idx_q] <= seq_q;
    end
    if (cmd_i.scan_run) begin
      rd_data_q <= mem_q[addr_q];
      rd_idx_q  <= addr_q;
    end
  end

  assign status_o.seq_gt    = (seq_q > ne_q);
  assign status_o.seq_eq    = (seq_q == ne_q);
  assign status_o.scan_done = scan_done;
  assign ack_o              = out_q;

endmodule

`default_nettype wire

/* design/tcpra_ctrl.sv */
// ----------------------------------------------------------------------------
// tcpra_ctrl
// Receiver controller: sequences classify, hold-set scan, commit, byte count
// and reply, and owns both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpra_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  input  tcpra_pkg::dp_status_t  status_i,
  output tcpra_pkg::dp_cmd_t     cmd_o
);
  import tcpra_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_vld_q, out_vld_d;
  logic        out_free;

  assign out_free = !out_vld_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        priority if (status_i.seq_gt) state_d = ST_INS_SCAN;
        else if (status_i.seq_eq)     state_d = ST_DRAIN_SCAN;
        else                          state_d = ST_COUNT;
      end
      ST_INS_SCAN: begin
        if (status_i.scan_done) state_d = ST_INS_COMMIT;
      end
      ST_INS_COMMIT: state_d = ST_COUNT;
      ST_DRAIN_SCAN: begin
        if (status_i.scan_done) state_d = ST_COUNT;
      end
      ST_COUNT: state_d = ST_REPLY;
      ST_REPLY: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_CLASSIFY: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.advance    = status_i.seq_eq;
      end
      ST_INS_SCAN: begin
        cmd_o.scan_run = !status_i.scan_done;
      end
      ST_INS_COMMIT: cmd_o.commit = 1'b1;
      ST_DRAIN_SCAN: begin
        cmd_o.drain    = 1'b1;
        cmd_o.scan_run = !status_i.scan_done;
      end
      ST_COUNT: cmd_o.count = 1'b1;
      ST_REPLY: cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_vld_d = out_vld_q;
    if (state_q == ST_REPLY && out_free) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

/* design/tcp_receiver_cumulative_ack_core.sv */
// ----------------------------------------------------------------------------
// tcp_receiver_cumulative_ack_core
// Receiver side of a segment transport: cumulative acknowledgement with a
// bounded out-of-order hold set and a received-byte counter.
//
//   Channel  | Dir | Handshake             | Payload
//   ---------+-----+-----------------------+-------------------------------
//   in       | in  | in_valid_i/in_ready_o | in_req_i  (seg_req_t)
//   out      | out | out_valid_o/out_ready_i | out_ack_o (ack_t)
//   config   | in  | APB psel/penable/pready | total_bytes at address 0
//
// One segment at a time, accept through reply. Below next_expected classify
// leads straight to count and reply; above it a hold-set scan and a commit
// come between, in order an advance and a drain scan; a scan reads one entry
// per cycle, and the drain ends after HoldDepth misses in a row.
// Reset clears next_expected, byte count, hold-set valid bits and total_bytes.
// A waiting acknowledgement stalls only the reply step; a held output register
// frees the next request to be accepted once the reply is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_receiver_cumulative_ack_core #(
  parameter int unsigned HoldDepth = tcpra_pkg::HOLD_DEPTH
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  tcpra_pkg::seg_req_t              in_req_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output tcpra_pkg::ack_t                  out_ack_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [tcpra_pkg::PADDR_W-1:0]    paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import tcpra_pkg::*;

  logic [31:0] total_q;
  logic        cfg_wr;
  dp_cmd_t     cmd;
  dp_status_t  status;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_IDX_TOTAL_BYTES) ? total_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cfg_wr && paddr[2] == REG_IDX_TOTAL_BYTES) begin
      total_q <= pwdata;
    end
  end

  tcpra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcpra_dpath #(
    .HoldDepth (HoldDepth)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (in_req_i),
    .total_bytes_i (total_q),
    .cmd_i         (cmd),
    .status_o      (status),
    .ack_o         (out_ack_o)
  );

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while a segment is in flight");

  a_overflow_not_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ack_o.set_overflow |-> !out_ack_o.was_new)
    else $error("dropped segment flagged as new");

  a_reply_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("acknowledgement appeared without segment work");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cumulative-ack segment receiver. Segments go in
// through a valid/ready driver fed from a queue. A predictor of the receiver
// state (next expected, hold set, byte count, total) runs on each accepted
// segment. The monitor checks each acknowledgement in order against the
// predicted ones. Phases vary total_bytes, payload sizes and idling.
// ----------------------------------------------------------------------------

module tb;
  import tcpra_pkg::*;

  localparam int unsigned MAX_REPORT  = 10;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned PHASE_ITEMS = 225;

  localparam logic [PADDR_W-1:0] ADDR_TOTAL = {REG_IDX_TOTAL_BYTES, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE = {~REG_IDX_TOTAL_BYTES, 2'b00};

  typedef enum logic {BYTES_WIDE, BYTES_NARROW} byte_mode_e;

  // DUT connections
  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  seg_req_t           in_req    = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ack_t               out_ack;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Stimulus and scoreboard storage
  seg_req_t    seg_q[$];
  ack_t        ack_q[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_req   = 1'b0;
  bit          pressure_taken = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned fail_cnt       = 0;
  int unsigned cyc_cnt        = 0;
  int unsigned n_acks = 0, n_new = 0, n_dup = 0, n_drop = 0, n_done = 0;

  // Generator side
  logic [31:0] gen_base  = '0;
  int unsigned gen_count = 0;
  byte_mode_e  byte_mode = BYTES_WIDE;

  // Predicted receiver state
  logic [31:0] total_cfg   = '0;
  logic [31:0] rx_next_seq = '0;
  logic [31:0] rx_byte_cnt = '0;
  logic        held_vld[HOLD_DEPTH];
  logic [31:0] held_sq[HOLD_DEPTH];

  tcp_receiver_cumulative_ack_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_ack_o   (out_ack),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      held_vld[i] = 1'b0;
      held_sq[i]  = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int find_held(logic [31:0] s);
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      if (held_vld[i] && held_sq[i] == s) return i;
    end
    return -1;
  endfunction

  function automatic ack_t ack_for_segment(seg_req_t seg);
    ack_t        a;
    logic        fresh;
    logic        ovf;
    int          hit;
    int          slot;
    logic [32:0] sum;
    fresh = 1'b0;
    ovf   = 1'b0;
    if (seg.seg_seq > rx_next_seq) begin
      // out of order: hold unless already held, drop if the set is full
      if (find_held(seg.seg_seq) < 0) begin
        slot = -1;
        for (int i = HOLD_DEPTH - 1; i >= 0; i--) begin
          if (!held_vld[i]) slot = i;
        end
        if (slot >= 0) begin
          held_vld[slot] = 1'b1;
          held_sq[slot]  = seg.seg_seq;
          fresh = 1'b1;
        end else begin
          ovf = 1'b1;
        end
      end
    end else if (seg.seg_seq == rx_next_seq) begin
      // in order: advance, then drain consecutive held entries
      fresh = 1'b1;
      rx_next_seq = rx_next_seq + 32'd1;
      for (int k = 0; k < HOLD_DEPTH; k++) begin
        hit = find_held(rx_next_seq);
        if (hit < 0) break;
        held_vld[hit] = 1'b0;
        rx_next_seq = rx_next_seq + 32'd1;
      end
    end
    if (fresh) begin
      sum = {1'b0, rx_byte_cnt} + {17'd0, seg.seg_bytes};
      rx_byte_cnt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    a.ack_expected  = rx_next_seq;
    a.ack_of_seq    = seg.seg_seq;
    a.was_new       = fresh;
    a.transfer_done = (rx_byte_cnt == total_cfg);
    a.set_overflow  = ovf;
    return a;
  endfunction

  function automatic bit note_fail();
    fail_cnt++;
    return fail_cnt <= MAX_REPORT;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!in_valid || in_ready) begin
      if (rst_n && seg_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_req   <= seg_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Ack receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (pressure_req && !pressure_taken) begin
      pressure_taken <= 1'b1;
      hold_left      <= LONG_HOLD;
      out_ready      <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check acks, predict accepted segments, track the register
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    ack_t want;
    ack_t pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_acks++;
        if (out_ack.was_new) n_new++; else n_dup++;
        if (out_ack.set_overflow) n_drop++;
        if (out_ack.transfer_done) n_done++;
        if (ack_q.size() == 0) begin
          if (note_fail())
            $display("%0t: ack with nothing pending: exp=%h seq=%h", $realtime,
                     out_ack.ack_expected, out_ack.ack_of_seq);
        end else begin
          want = ack_q.pop_front();
          if (out_ack.ack_expected  !== want.ack_expected  ||
              out_ack.ack_of_seq    !== want.ack_of_seq    ||
              out_ack.was_new       !== want.was_new       ||
              out_ack.transfer_done !== want.transfer_done ||
              out_ack.set_overflow  !== want.set_overflow) begin
            if (note_fail()) begin
              $display("%0t: ack differs: want exp=%h seq=%h new=%b done=%b ovf=%b",
                       $realtime, want.ack_expected, want.ack_of_seq, want.was_new,
                       want.transfer_done, want.set_overflow);
              $display("%0t:              got  exp=%h seq=%h new=%b done=%b ovf=%b",
                       $realtime, out_ack.ack_expected, out_ack.ack_of_seq,
                       out_ack.was_new, out_ack.transfer_done, out_ack.set_overflow);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        pred  = ack_for_segment(in_req);
        ack_q = {ack_q, pred};
      end
      if (psel && penable && pready && paddr == ADDR_TOTAL) begin
        if (pwrite) begin
          total_cfg = pwdata;
        end else if (prdata !== total_cfg) begin
          if (note_fail())
            $display("%0t: total_bytes read: want %h got %h", $realtime,
                     total_cfg, prdata);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d acks pending", cyc_cnt, ack_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Register port access
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_total(input logic [31:0] value);
    apb_access(1'b1, ADDR_TOTAL, value);
    apb_access(1'b0, ADDR_TOTAL, '0);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  task automatic push_seg(input logic [31:0] s, input logic [15:0] b);
    seg_req_t r;
    r.seg_seq   = s;
    r.seg_bytes = b;
    seg_q = {seg_q, r};
    gen_count++;
  endtask

  function automatic logic [15:0] pick_bytes();
    int unsigned roll;
    roll = $urandom_range(9);
    if (byte_mode == BYTES_NARROW) return 16'($urandom_range(7, 0));
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Random high sequence that lands while the hold set is full
  function automatic logic [31:0] junk_seq();
    logic [31:0] v;
    v = $urandom;
    if (v <= gen_base + 32'd64) v = v | 32'h8000_0000;
    return v;
  endfunction

  task automatic shuffle(ref logic [31:0] win[24], input int unsigned n);
    int unsigned j;
    logic [31:0] t;
    for (int i = int'(n) - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = win[i];
      win[i] = win[j];
      win[j] = t;
    end
  endtask

  // One well-formed window of segments starting at gen_base, or some noise
  task automatic gen_window();
    logic [31:0] win[24];
    int unsigned w;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 30) begin
      // in-order run
      w = $urandom_range(8, 1);
      for (int i = 0; i < w; i++) push_seg(gen_base + i, pick_bytes());
      gen_base = gen_base + w;
    end else if (kind < 70) begin
      // reordered window that fits in the hold set, with duplicates
      w = $urandom_range(16, 2);
      for (int i = 0; i < w; i++) win[i] = gen_base + i;
      shuffle(win, w);
      for (int i = 0; i < w; i++) begin
        push_seg(win[i], pick_bytes());
        if ($urandom_range(99) < 15) push_seg(win[$urandom_range(i, 0)], pick_bytes());
      end
      gen_base = gen_base + w;
    end else if (kind < 85) begin
      // fill the hold set, overflow it, then fill the gap and retransmit
      w = $urandom_range(24, 17);
      for (int i = 0; i < 16; i++) win[i] = gen_base + 1 + i;
      shuffle(win, 16);
      for (int i = 0; i < 16; i++) begin
        push_seg(win[i], pick_bytes());
        if ($urandom_range(9) == 0) push_seg(win[$urandom_range(i, 0)], pick_bytes());
      end
      repeat ($urandom_range(4, 1)) push_seg(junk_seq(), pick_bytes());
      for (int i = 17; i < w; i++) push_seg(gen_base + i, pick_bytes());
      push_seg(gen_base, pick_bytes());
      for (int i = 17; i < w; i++) push_seg(gen_base + i, pick_bytes());
      gen_base = gen_base + w;
    end else begin
      // stale retransmissions below the expected sequence
      repeat ($urandom_range(4, 1)) push_seg($urandom_range(gen_base - 1, 0), pick_bytes());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (seg_q.size() != 0 || in_valid || ack_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input byte_mode_e mode);
    int unsigned start;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    byte_mode      = mode;
    start = gen_count;
    while (gen_count - start < PHASE_ITEMS) gen_window();
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    apb_access(1'b0, ADDR_TOTAL, '0);

    // Directed: total 0, empty set, then fill, duplicate, overflow, drain
    @(negedge clk);
    push_seg(32'd0, 16'h0000);
    push_seg(32'd0, 16'hFFFF);
    for (int i = 2; i <= 17; i++) push_seg(i, (i == 2) ? 16'hFFFF : 16'(i));
    push_seg(32'd5, 16'h0001);
    push_seg(32'hFFFF_FFFF, 16'hFFFF);
    push_seg(32'h8000_0000, 16'h0001);
    push_seg(32'hAAAA_AAAA, 16'h5555);
    push_seg(32'd18, 16'hAAAA);
    push_seg(32'd1, 16'h8000);
    push_seg(32'd18, 16'h0000);
    gen_base = 32'd19;
    wait_drained();

    // Unmapped address must leave total_bytes alone
    apb_access(1'b1, ADDR_SPARE, 32'h1234_5678);
    apb_access(1'b0, ADDR_TOTAL, '0);

    // No idling, never done; long ack hold-off at the start
    set_total(32'hFFFF_FFFF);
    @(negedge clk);
    pressure_req = 1'b1;
    run_phase(0, 0, BYTES_WIDE);

    // Sender gaps, small payloads so the count walks through the total
    set_total(rx_byte_cnt + 32'd300);
    run_phase(62, 0, BYTES_NARROW);

    // Receiver stalls, done right away until new bytes arrive
    set_total(rx_byte_cnt);
    run_phase(0, 62, BYTES_WIDE);

    // Both sides idle
    set_total(rx_byte_cnt + 32'd500);
    run_phase(38, 38, BYTES_NARROW);

    $display("Covered %0d segments in five phases: %0d new, %0d duplicate or dropped,",
             n_acks, n_new, n_dup);
    $display("%0d dropped on a full set, %0d with transfer done.", n_drop, n_done);
    if (fail_cnt == 0 && ack_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures, %0d acks missing", fail_cnt, ack_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
